[rtl/core/csim_pkg.sv]
// Shared types and constants for the cosine similarity core.
// Used by csim_front, csim_queue, csim_back and cosine_similarity_core.
`timescale 1ns / 1ps
`default_nettype none
package csim_pkg;

  localparam int AccBits  = 48;
  localparam int ElemBits = 16;
  localparam int ProdBits = 2 * AccBits;
  localparam int RemBits  = 128;
  localparam int RootBits = 16;
  localparam int CntBits  = 6;

  localparam logic [CntBits-1:0] MulFirst  = CntBits'(AccBits - 1);
  localparam logic [CntBits-1:0] DivFirst  = CntBits'(2 * RootBits);
  localparam logic [CntBits-1:0] SqrtFirst = CntBits'(RootBits - 1);

  typedef struct packed {
    logic signed [AccBits-1:0] dot;
    logic [AccBits-1:0]        sq_a;
    logic [AccBits-1:0]        sq_b;
  } sums_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_DIV  = 5'b00100,
    ST_SQRT = 5'b01000,
    ST_EMIT = 5'b10000
  } back_state_e;

endpackage
`default_nettype wire

[rtl/core/csim_front.sv]
// Front end: accepts element pairs and keeps the three saturating sums.
// Pushes the finished sums into the queue on the last pair. Uses csim_pkg.
`timescale 1ns / 1ps
`default_nettype none
module csim_front
  import csim_pkg::*;
(
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic signed [ElemBits-1:0] elem_a_i,
  input  wire logic signed [ElemBits-1:0] elem_b_i,
  input  wire logic                       last_i,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire q_status_t                  q_status_i,
  output logic                            push_o,
  output sums_t                           push_data_o
);

  function automatic logic signed [AccBits-1:0] sat_add(
    input logic signed [AccBits-1:0]    acc,
    input logic signed [2*ElemBits-1:0] term
  );
    logic signed [AccBits:0] s;
    logic signed [AccBits-1:0] r;
    s = {acc[AccBits-1], acc} + (AccBits+1)'(term);
    if (s[AccBits] != s[AccBits-1]) begin
      r = s[AccBits] ? {1'b1, {(AccBits-1){1'b0}}} : {1'b0, {(AccBits-1){1'b1}}};
    end else begin
      r = s[AccBits-1:0];
    end
    return r;
  endfunction

  sums_t sums_q, sums_d;
  logic signed [2*ElemBits-1:0] p_ab, p_aa, p_bb;
  logic accept;

  assign in_stall_o = q_status_i.full;
  assign accept     = in_valid_i && !in_stall_o;

  assign p_ab = elem_a_i * elem_b_i;
  assign p_aa = elem_a_i * elem_a_i;
  assign p_bb = elem_b_i * elem_b_i;

  always_comb begin
    sums_d.dot  = sat_add(sums_q.dot, p_ab);
    sums_d.sq_a = sat_add(sums_q.sq_a, p_aa);
    sums_d.sq_b = sat_add(sums_q.sq_b, p_bb);
  end

  assign push_o      = accept && last_i;
  assign push_data_o = sums_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sums_q <= '0;
    end else if (accept) begin
      sums_q <= last_i ? '0 : sums_d;
    end
  end

endmodule
`default_nettype wire

[rtl/core/csim_queue.sv]
// Two-entry queue of finished sums between the front and back ends.
// Uses csim_pkg.
`timescale 1ns / 1ps
`default_nettype none
module csim_queue
  import csim_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire sums_t push_data_i,
  input  wire logic  pop_i,
  output sums_t      head_o,
  output q_status_t  status_o
);

  sums_t      mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign head_o          = mem_q[rd_ptr_q];
  assign status_o.full   = count_q == 2'd2;
  assign status_o.empty  = count_q == 2'd0;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      count_q <= count_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule
`default_nettype wire

[rtl/core/csim_back.sv]
// Back end: shift-add products, restoring divide and bit-serial square root.
// Holds the result in an output register. Uses csim_pkg.
`timescale 1ns / 1ps
`default_nettype none
module csim_back
  import csim_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire sums_t        head_i,
  input  wire q_status_t    q_status_i,
  output logic              pop_o,
  output logic signed [15:0] cosine_value_o,
  output logic              zero_length_o,
  output logic              out_valid_o,
  input  wire logic         out_stall_i
);

  function automatic logic [15:0] encode(input logic neg, input logic [RootBits-1:0] q);
    logic [15:0] r;
    if (neg) begin
      r = q[RootBits-1] ? 16'h8000 : 16'(-q);
    end else begin
      r = q[RootBits-1] ? 16'h7FFF : q;
    end
    return r;
  endfunction

  back_state_e state_q;
  logic [CntBits-1:0] cnt_q;
  logic out_valid_q, out_valid_d;
  logic [15:0] cos_q;
  logic zero_out_q;

  logic neg_q, zero_q;
  logic [AccBits-1:0] mag_q, sa_q, sb_q;
  logic [ProdBits-1:0] dd_q, p_q;
  logic [RemBits-1:0] rem_q, dv_q;
  logic [2*RootBits-1:0] y_q;
  logic [RootBits-1:0] root_q;
  logic [15:0] res_q;

  logic [ProdBits-1:0] mul_dd_d, mul_p_d;
  logic div_ge;
  logic [RemBits-1:0] div_diff;
  logic [RootBits-1:0] sq_cand, root_d;
  logic [2*RootBits-1:0] sq_sq;
  logic out_free, head_zero;

  assign mul_dd_d = {dd_q[ProdBits-2:0], 1'b0}
                  + (mag_q[cnt_q] ? {{AccBits{1'b0}}, mag_q} : '0);
  assign mul_p_d  = {p_q[ProdBits-2:0], 1'b0}
                  + (sb_q[cnt_q] ? {{AccBits{1'b0}}, sa_q} : '0);
  assign div_ge   = rem_q >= dv_q;
  assign div_diff = rem_q - dv_q;
  assign sq_cand  = root_q | (RootBits'(1) << cnt_q[3:0]);
  assign sq_sq    = sq_cand * sq_cand;
  assign root_d   = (sq_sq <= y_q) ? sq_cand : root_q;

  assign out_free  = !out_valid_q || !out_stall_i;
  assign head_zero = (head_i.sq_a == '0) || (head_i.sq_b == '0);
  assign pop_o     = (state_q == ST_IDLE) && !q_status_i.empty;

  assign cosine_value_o = cos_q;
  assign zero_length_o  = zero_out_q;
  assign out_valid_o    = out_valid_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if ((state_q == ST_EMIT) && out_free) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (!q_status_i.empty) begin
          neg_q  <= head_i.dot[AccBits-1];
          mag_q  <= head_i.dot[AccBits-1] ? AccBits'(-head_i.dot) : head_i.dot;
          sa_q   <= head_i.sq_a;
          sb_q   <= head_i.sq_b;
          dd_q   <= '0;
          p_q    <= '0;
          res_q  <= '0;
          zero_q <= 1'b1;
        end
      end
      ST_MUL: begin
        dd_q   <= mul_dd_d;
        p_q    <= mul_p_d;
        zero_q <= 1'b0;
        if (cnt_q == '0) begin
          rem_q <= {2'b00, mul_dd_d, 30'b0};
          dv_q  <= {mul_p_d, 32'b0};
          y_q   <= '0;
        end
      end
      ST_DIV: begin
        dv_q <= dv_q >> 1;
        if (cnt_q == DivFirst) begin
          if (div_ge) begin
            res_q <= encode(neg_q, {RootBits{1'b1}});
          end
        end else begin
          if (div_ge) begin
            rem_q <= div_diff;
          end
          y_q <= {y_q[2*RootBits-2:0], div_ge};
        end
        if (cnt_q == '0) begin
          root_q <= '0;
        end
      end
      ST_SQRT: begin
        root_q <= root_d;
        if (cnt_q == '0) begin
          res_q <= encode(neg_q, root_d);
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          cos_q      <= res_q;
          zero_out_q <= zero_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      case (state_q)
        ST_IDLE: begin
          if (!q_status_i.empty) begin
            if (head_zero) begin
              state_q <= ST_EMIT;
            end else begin
              cnt_q   <= MulFirst;
              state_q <= ST_MUL;
            end
          end
        end
        ST_MUL: begin
          if (cnt_q == '0) begin
            cnt_q   <= DivFirst;
            state_q <= ST_DIV;
          end else begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
        ST_DIV: begin
          if (cnt_q == DivFirst && div_ge) begin
            state_q <= ST_EMIT;
          end else if (cnt_q == '0) begin
            cnt_q   <= SqrtFirst;
            state_q <= ST_SQRT;
          end else begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
        ST_SQRT: begin
          if (cnt_q == '0) begin
            state_q <= ST_EMIT;
          end else begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

[rtl/core/cosine_similarity_core.sv]
// Top level of the streaming cosine similarity core.
// Instantiates csim_front, csim_queue and csim_back; uses csim_pkg.
//
//   Channel  Valid        Stall        Beat
//   input    in_valid_i   in_stall_o   elem_a_i, elem_b_i, last_i
//   output   out_valid_o  out_stall_i  cosine_value_o, zero_length_o
//
// The front end takes one input beat per cycle unless in_stall_o is high, and adds
// into saturating sums. The back end works on one vector at a time: a load step,
// 48 shift-add steps, 33 divide steps, 16 square-root steps and a hand-off step.
// Two finished vectors can wait in the queue; when it is full, in_stall_o rises.
// A zero-length vector skips the arithmetic, a saturated one the square root.
// Reset is asynchronous and clears the sums, the queue and the result valid.
`timescale 1ns / 1ps
`default_nettype none
module cosine_similarity_core
  import csim_pkg::*;
(
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic signed [ElemBits-1:0] elem_a_i,
  input  wire logic signed [ElemBits-1:0] elem_b_i,
  input  wire logic                       last_i,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  output logic signed [15:0]              cosine_value_o,
  output logic                            zero_length_o,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i
);

  q_status_t q_status;
  sums_t     push_data, head;
  logic      push, pop;

  csim_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .elem_a_i    (elem_a_i),
    .elem_b_i    (elem_b_i),
    .last_i      (last_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .q_status_i  (q_status),
    .push_o      (push),
    .push_data_o (push_data)
  );

  csim_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .status_o    (q_status)
  );

  csim_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head),
    .q_status_i     (q_status),
    .pop_o          (pop),
    .cosine_value_o (cosine_value_o),
    .zero_length_o  (zero_length_o),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i)
  );

endmodule
`default_nettype wire
